>>> rtl/iff_pkg.sv
package iff_pkg;

	// conversion kinds carried on the input tuser
	localparam logic [2:0] OP_UDEC  = 3'd0;
	localparam logic [2:0] OP_SDEC  = 3'd1;
	localparam logic [2:0] OP_HEXL  = 3'd2;
	localparam logic [2:0] OP_HEXU  = 3'd3;
	localparam logic [2:0] OP_PTR   = 3'd4;
	localparam logic [2:0] OP_CHAR  = 3'd5;
	localparam logic [2:0] OP_PCT   = 3'd6;
	// unused selector, rendered as a literal percent
	localparam logic [2:0] OP_SPARE = 3'd7;

	// digit register geometry
	localparam int VAL_W  = 64;
	localparam int NDIG   = 20;
	localparam int DIG_W  = 4 * NDIG;
	localparam int CNT_W  = 5;
	localparam int ITER_W = 7;
	localparam logic [ITER_W-1:0] ITER_N = ITER_W'(VAL_W);

	// ascii codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_UC_A  = 8'h41;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_NORM,
		S_PREP,
		S_EMIT
	} iff_state_t;

	// commands from the sequencer to the digit unit
	typedef struct packed {
		logic load_dec;
		logic load_hex;
		logic load_one;
		logic step;
		logic shift;
	} iff_cmd_t;

	// status from the digit unit
	typedef struct packed {
		logic [3:0]       top;
		logic [CNT_W-1:0] cnt;
		logic             iter_zero;
	} iff_stat_t;

	// one digit to its ascii code
	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] base;
		begin
			base = upper ? CH_UC_A : CH_LC_A;
			if (d < 4'd10) begin
				digit_char = CH_ZERO + {4'h0, d};
			end else begin
				digit_char = base + {4'h0, d} - 8'd10;
			end
		end
	endfunction

endpackage

>>> rtl/iff_digit_unit.sv
module iff_digit_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  iff_pkg::iff_cmd_t      cmd,
	input  logic [63:0]            value,
	output iff_pkg::iff_stat_t     stat
);
	import iff_pkg::*;

	logic [DIG_W-1:0]  digits_q;
	logic [VAL_W-1:0]  bin_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ITER_W-1:0] iter_q;
	logic [DIG_W-1:0]  adj;

	// add-3 correction on every bcd digit before the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (digits_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = digits_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = digits_q[4*i +: 4];
			end
		end
	end

	// count and iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			iter_q <= '0;
		end else if (cmd.load_dec) begin
			cnt_q  <= CNT_W'(NDIG);
			iter_q <= ITER_N;
		end else if (cmd.load_hex) begin
			cnt_q  <= CNT_W'(VAL_W / 4);
			iter_q <= '0;
		end else if (cmd.load_one) begin
			cnt_q  <= CNT_W'(1);
			iter_q <= '0;
		end else if (cmd.step) begin
			iter_q <= iter_q - ITER_W'(1);
		end else if (cmd.shift) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// shared shift datapath: double dabble steps and digit shifts
	always_ff @(posedge clk) begin
		if (cmd.load_dec) begin
			digits_q <= '0;
			bin_q    <= value;
		end else if (cmd.load_hex) begin
			digits_q <= {value, {(DIG_W - VAL_W){1'b0}}};
		end else if (cmd.step) begin
			digits_q <= {adj[DIG_W-2:0], bin_q[VAL_W-1]};
			bin_q    <= {bin_q[VAL_W-2:0], 1'b0};
		end else if (cmd.shift) begin
			digits_q <= {digits_q[DIG_W-5:0], 4'h0};
		end
	end

	assign stat.top       = digits_q[DIG_W-1 -: 4];
	assign stat.cnt       = cnt_q;
	assign stat.iter_zero = (iter_q == '0);

endmodule

>>> rtl/integer_field_formatter.sv
// sequence: a request is taken in S_IDLE; decimal kinds then run S_CONV (64 shift steps
// and an exit check) and S_NORM, which drops leading zero digits, hex kinds (HEXL, HEXU)
// run only S_NORM, the other kinds neither; an S_PREP setup state follows
// the first character is registered in S_EMIT, then one per cycle unless m_tready stalls
// throughput: one request at a time, the next is taken as the last character is presented
// reset: arst_n clears the sequencer and the output valid; no pending transaction survives
module integer_field_formatter #(
	parameter int WIDTH_LIMIT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // value[63:0], width[71:64], zero_fill[72]
	input  logic [2:0]  s_tuser,   // op[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // ch[7:0]
	output logic        m_tlast
);
	import iff_pkg::*;

	localparam int MAG_W = $clog2(WIDTH_LIMIT + 1);

	iff_state_t state_q, state_d;
	iff_cmd_t   cmd;
	iff_stat_t  stat;

	logic [2:0]       in_op;
	logic [63:0]      in_value;
	logic [7:0]       in_width;
	logic             in_neg;
	logic [63:0]      in_mag_val;
	logic [7:0]       in_abs;
	logic [MAG_W-1:0] in_mag;
	logic             accept;

	logic             sign_q, left_q, fill_q, upper_q, lit_q;
	logic [7:0]       lit_ch_q;
	logic [MAG_W-1:0] mag_q, pad_q;
	logic [7:0]       ch_q;
	logic             last_q, m_tvalid_q;

	logic             norm_more;
	logic             emit_go;
	logic             emit_digit;
	logic [7:0]       fill_ch;
	logic [7:0]       ch_d;
	logic [MAG_W-1:0] pad_d;
	logic             sign_d;
	logic [CNT_W-1:0] cnt_d;
	logic             last_d;
	logic [MAG_W-1:0] len;

	// input field decode
	assign in_op      = s_tuser;
	assign in_value   = s_tdata[63:0];
	assign in_width   = s_tdata[71:64];
	assign in_neg     = (in_op == OP_SDEC) && in_value[63];
	assign in_mag_val = in_neg ? (64'd0 - in_value) : in_value;
	assign in_abs     = in_width[7] ? (8'd0 - in_width) : in_width;
	assign in_mag     = (in_abs > 8'(WIDTH_LIMIT)) ? MAG_W'(WIDTH_LIMIT) : MAG_W'(in_abs);
	assign accept     = s_tvalid && s_tready;

	iff_digit_unit u_digit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.value  (in_mag_val),
		.stat   (stat)
	);

	assign norm_more = (stat.cnt > CNT_W'(1)) && (stat.top == 4'h0);
	assign emit_go   = (state_q == S_EMIT) && (!m_tvalid_q || m_tready);
	assign fill_ch   = fill_q ? CH_ZERO : CH_SPACE;
	assign len       = MAG_W'(stat.cnt) + MAG_W'(sign_q);

	// character selection: leading pad, sign, digits, trailing pad
	always_comb begin
		ch_d       = fill_ch;
		pad_d      = pad_q;
		sign_d     = sign_q;
		cnt_d      = stat.cnt;
		emit_digit = 1'b0;
		if (!left_q && pad_q != '0) begin
			pad_d = pad_q - MAG_W'(1);
		end else if (sign_q) begin
			ch_d   = CH_MINUS;
			sign_d = 1'b0;
		end else if (stat.cnt != '0) begin
			ch_d       = lit_q ? lit_ch_q : digit_char(stat.top, upper_q);
			cnt_d      = stat.cnt - CNT_W'(1);
			emit_digit = 1'b1;
		end else begin
			pad_d = pad_q - MAG_W'(1);
		end
		last_d = (pad_d == '0) && !sign_d && (cnt_d == '0);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					unique case (in_op) inside
						OP_UDEC, OP_SDEC:         state_d = S_CONV;
						OP_HEXL, OP_HEXU:         state_d = S_NORM;
						default:                  state_d = S_PREP;
					endcase
				end
			end
			S_CONV: begin
				if (stat.iter_zero) state_d = S_NORM;
			end
			S_NORM: begin
				if (!norm_more) state_d = S_PREP;
			end
			S_PREP: state_d = S_EMIT;
			S_EMIT: begin
				if (emit_go && last_d) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					unique case (in_op) inside
						OP_UDEC, OP_SDEC:         cmd.load_dec = 1'b1;
						OP_HEXL, OP_HEXU, OP_PTR: cmd.load_hex = 1'b1;
						default:                  cmd.load_one = 1'b1;
					endcase
				end
			end
			S_CONV: cmd.step  = !stat.iter_zero;
			S_NORM: cmd.shift = norm_more;
			S_PREP: cmd       = '0;
			S_EMIT: cmd.shift = emit_go && emit_digit;
			default: cmd      = '0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// request fields and output register
	always_ff @(posedge clk) begin
		if (accept) begin
			sign_q   <= in_neg;
			left_q   <= in_width[7];
			fill_q   <= s_tdata[72];
			mag_q    <= in_mag;
			upper_q  <= (in_op == OP_HEXU) || (in_op == OP_PTR);
			lit_q    <= (in_op == OP_CHAR) || (in_op == OP_PCT) || (in_op == OP_SPARE);
			lit_ch_q <= (in_op == OP_CHAR) ? in_value[7:0] : CH_PCT;
		end
		if (state_q == S_PREP) begin
			pad_q <= (mag_q > len) ? (mag_q - len) : '0;
		end
		if (emit_go) begin
			pad_q  <= pad_d;
			sign_q <= sign_d;
			ch_q   <= ch_d;
			last_q <= last_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = ch_q;
	assign m_tlast  = last_q;

endmodule
